### hw/rtl/wvc_pkg.sv
package wvc_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_EXTENT_DEF = 16;
  localparam int DATA_WIDTH_DEF = 64;

  // Fixed field widths
  localparam int COORD_W    = 16;
  localparam int SIZE_W     = 5;
  localparam int OP_W       = 2;
  localparam int STATUS_W   = 2;
  localparam int ADDR_W     = 5;
  localparam int PDATA_W    = 32;
  localparam int FIFO_DEPTH = 4;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_EMPTY   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_SIZE_X   = 3'd3,
    REG_SIZE_Y   = 3'd4,
    REG_SIZE_Z   = 3'd5
  } reg_idx_t;

  typedef enum logic {
    BK_RUN   = 1'b0,
    BK_SWEEP = 1'b1
  } back_state_t;

  // Window registers as seen by the front end; sizes are already clamped
  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0] origin_z;
    logic [SIZE_W-1:0]  size_x;
    logic [SIZE_W-1:0]  size_y;
    logic [SIZE_W-1:0]  size_z;
  } cfg_t;

  // Index width for n values, never below one bit
  function automatic int bits_for(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

### hw/rtl/windowed_3d_valid_cache.sv
// Channel | Signals                                        | Transfer when
// item    | start, busy, operation, cell_x/y/z, write_data | start && !busy at clk rise
// result  | done, status, read_data                        | done high (one cycle)
// config  | psel, penable, pwrite, paddr, pwdata, prdata   | psel && penable && pwrite
//
// A write or read is accepted at one edge, then passes front-end stages s1 and s2,
// the queue and the registered memory reads to the result ports. Items sustain one
// per cycle while busy is low, set by the back end's pops and the four-entry queue
// with its credit count. A clear sweeps all MAX_EXTENT^3 valid memory entries one
// entry a cycle, and busy stays high meanwhile. Reset runs the same sweep before
// the first item is taken. Results cannot be stalled; busy is the only hold.
module windowed_3d_valid_cache #(
  parameter int MAX_EXTENT = wvc_pkg::MAX_EXTENT_DEF,
  parameter int DATA_WIDTH = wvc_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [wvc_pkg::OP_W-1:0]     operation,
  input  logic [wvc_pkg::COORD_W-1:0]  cell_x,
  input  logic [wvc_pkg::COORD_W-1:0]  cell_y,
  input  logic [wvc_pkg::COORD_W-1:0]  cell_z,
  input  logic [DATA_WIDTH-1:0]        write_data,
  output logic                         done,
  output logic [wvc_pkg::STATUS_W-1:0] status,
  output logic [DATA_WIDTH-1:0]        read_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [wvc_pkg::ADDR_W-1:0]   paddr,
  input  logic [wvc_pkg::PDATA_W-1:0]  pwdata,
  output logic [wvc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int AW      = wvc_pkg::bits_for(MAX_EXTENT * MAX_EXTENT * MAX_EXTENT);
  localparam int QDEPTH  = wvc_pkg::FIFO_DEPTH;
  localparam int QCW     = $clog2(QDEPTH + 1);
  localparam int ENTRY_W = wvc_pkg::OP_W + 1 + AW + DATA_WIDTH;

  wvc_pkg::cfg_t             cfg;
  logic                      accept;

  logic                      push;
  logic [wvc_pkg::OP_W-1:0]  push_op;
  logic                      push_inside;
  logic [AW-1:0]             push_idx;
  logic [DATA_WIDTH-1:0]     push_data;
  logic [1:0]                inflight;

  logic [ENTRY_W-1:0]        push_entry, head_entry;
  logic                      q_empty;
  logic [QCW-1:0]            q_count;
  logic                      pop;
  logic                      sweeping;

  logic [wvc_pkg::OP_W-1:0]  head_op;
  logic                      head_inside;
  logic [AW-1:0]             head_idx;
  logic [DATA_WIDTH-1:0]     head_data;
  logic [QCW:0]              credit;

  // Hold new items while the queue could overflow or a sweep runs
  assign credit = (QCW+1)'(q_count) + (QCW+1)'(inflight);
  assign busy   = sweeping || (credit >= (QCW+1)'(QDEPTH));
  assign accept = start && !busy;

  wvc_regs #(
    .MAX_EXTENT (MAX_EXTENT)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  wvc_front #(
    .MAX_EXTENT (MAX_EXTENT),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .operation   (operation),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .cell_z      (cell_z),
    .write_data  (write_data),
    .cfg         (cfg),
    .push        (push),
    .push_op     (push_op),
    .push_inside (push_inside),
    .push_idx    (push_idx),
    .push_data   (push_data),
    .inflight    (inflight)
  );

  // Pack and unpack queue entries
  assign push_entry = {push_op, push_inside, push_idx, push_data};
  assign {head_op, head_inside, head_idx, head_data} = head_entry;

  wvc_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .empty      (q_empty),
    .count      (q_count)
  );

  wvc_back #(
    .MAX_EXTENT (MAX_EXTENT),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .empty        (q_empty),
    .entry_op     (head_op),
    .entry_inside (head_inside),
    .entry_idx    (head_idx),
    .entry_data   (head_data),
    .pop          (pop),
    .done         (done),
    .status       (status),
    .read_data    (read_data),
    .sweeping     (sweeping)
  );

endmodule

### hw/rtl/wvc_regs.sv
module wvc_regs #(
  parameter int MAX_EXTENT = wvc_pkg::MAX_EXTENT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [wvc_pkg::ADDR_W-1:0]  paddr,
  input  logic [wvc_pkg::PDATA_W-1:0] pwdata,
  output logic [wvc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output wvc_pkg::cfg_t               cfg
);

  logic                        wr_en;
  wvc_pkg::reg_idx_t           reg_sel;
  logic [wvc_pkg::SIZE_W-1:0]  wsize;
  logic [wvc_pkg::SIZE_W-1:0]  wsize_clamped;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = wvc_pkg::reg_idx_t'(paddr[4:2]);

  // Limit an extent to the largest window the store holds
  assign wsize         = pwdata[wvc_pkg::SIZE_W-1:0];
  assign wsize_clamped = (int'(wsize) > MAX_EXTENT) ? wvc_pkg::SIZE_W'(MAX_EXTENT) : wsize;

  // Take a register write transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        wvc_pkg::REG_ORIGIN_X: cfg.origin_x <= pwdata[wvc_pkg::COORD_W-1:0];
        wvc_pkg::REG_ORIGIN_Y: cfg.origin_y <= pwdata[wvc_pkg::COORD_W-1:0];
        wvc_pkg::REG_ORIGIN_Z: cfg.origin_z <= pwdata[wvc_pkg::COORD_W-1:0];
        wvc_pkg::REG_SIZE_X:   cfg.size_x   <= wsize_clamped;
        wvc_pkg::REG_SIZE_Y:   cfg.size_y   <= wsize_clamped;
        wvc_pkg::REG_SIZE_Z:   cfg.size_z   <= wsize_clamped;
        default: ;
      endcase
    end
  end

  // Return the addressed register
  always_comb begin
    case (reg_sel)
      wvc_pkg::REG_ORIGIN_X: prdata = wvc_pkg::PDATA_W'(cfg.origin_x);
      wvc_pkg::REG_ORIGIN_Y: prdata = wvc_pkg::PDATA_W'(cfg.origin_y);
      wvc_pkg::REG_ORIGIN_Z: prdata = wvc_pkg::PDATA_W'(cfg.origin_z);
      wvc_pkg::REG_SIZE_X:   prdata = wvc_pkg::PDATA_W'(cfg.size_x);
      wvc_pkg::REG_SIZE_Y:   prdata = wvc_pkg::PDATA_W'(cfg.size_y);
      wvc_pkg::REG_SIZE_Z:   prdata = wvc_pkg::PDATA_W'(cfg.size_z);
      default:               prdata = '0;
    endcase
  end

endmodule

### hw/rtl/wvc_front.sv
module wvc_front #(
  parameter int MAX_EXTENT = wvc_pkg::MAX_EXTENT_DEF,
  parameter int DATA_WIDTH = wvc_pkg::DATA_WIDTH_DEF,
  localparam int IW = wvc_pkg::bits_for(MAX_EXTENT),
  localparam int TW = wvc_pkg::bits_for(MAX_EXTENT * MAX_EXTENT),
  localparam int AW = wvc_pkg::bits_for(MAX_EXTENT * MAX_EXTENT * MAX_EXTENT)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [wvc_pkg::OP_W-1:0]    operation,
  input  logic [wvc_pkg::COORD_W-1:0] cell_x,
  input  logic [wvc_pkg::COORD_W-1:0] cell_y,
  input  logic [wvc_pkg::COORD_W-1:0] cell_z,
  input  logic [DATA_WIDTH-1:0]       write_data,
  input  wvc_pkg::cfg_t               cfg,
  output logic                        push,
  output logic [wvc_pkg::OP_W-1:0]    push_op,
  output logic                        push_inside,
  output logic [AW-1:0]               push_idx,
  output logic [DATA_WIDTH-1:0]       push_data,
  output logic [1:0]                  inflight
);

  localparam int CW = wvc_pkg::COORD_W;
  localparam int SW = wvc_pkg::SIZE_W;

  logic signed [CW:0] dx_full, dy_full, dz_full;
  logic               in_x, in_y, in_z;

  logic                         s1_valid;
  logic [wvc_pkg::OP_W-1:0]     s1_op;
  logic                         s1_inside;
  logic [IW-1:0]                s1_dx, s1_dy, s1_dz;
  logic [DATA_WIDTH-1:0]        s1_data;

  logic                         s2_valid;
  logic [wvc_pkg::OP_W-1:0]     s2_op;
  logic                         s2_inside;
  logic [IW-1:0]                s2_dx;
  logic [TW-1:0]                s2_t;
  logic [DATA_WIDTH-1:0]        s2_data;

  logic [SW+IW-1:0]             yz_prod;
  logic [SW+TW-1:0]             xt_prod;

  // Offsets from the window corner, exact in one extra bit
  assign dx_full = $signed({cell_x[CW-1], cell_x}) - $signed({cfg.origin_x[CW-1], cfg.origin_x});
  assign dy_full = $signed({cell_y[CW-1], cell_y}) - $signed({cfg.origin_y[CW-1], cfg.origin_y});
  assign dz_full = $signed({cell_z[CW-1], cell_z}) - $signed({cfg.origin_z[CW-1], cfg.origin_z});

  // Inside when not negative and below the extent
  assign in_x = !dx_full[CW] && (dx_full[CW-1:0] < CW'(cfg.size_x));
  assign in_y = !dy_full[CW] && (dy_full[CW-1:0] < CW'(cfg.size_y));
  assign in_z = !dz_full[CW] && (dz_full[CW-1:0] < CW'(cfg.size_z));

  // Stage 1: classify the item against the window
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op     <= operation;
      s1_inside <= in_x && in_y && in_z;
      s1_dx     <= dx_full[IW-1:0];
      s1_dy     <= dy_full[IW-1:0];
      s1_dz     <= dz_full[IW-1:0];
      s1_data   <= write_data;
    end
  end

  // Stage 2: fold z into the y row
  assign yz_prod = (SW+IW)'(cfg.size_y) * (SW+IW)'(s1_dz);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_op     <= s1_op;
      s2_inside <= s1_inside;
      s2_dx     <= s1_dx;
      s2_t      <= TW'(yz_prod) + TW'(s1_dy);
      s2_data   <= s1_data;
    end
  end

  // Final cell index, pushed into the queue with the item
  assign xt_prod     = (SW+TW)'(cfg.size_x) * (SW+TW)'(s2_t);
  assign push        = s2_valid;
  assign push_op     = s2_op;
  assign push_inside = s2_inside;
  assign push_idx    = AW'(xt_prod) + AW'(s2_dx);
  assign push_data   = s2_data;
  assign inflight    = 2'(s1_valid) + 2'(s2_valid);

endmodule

### hw/rtl/wvc_fifo.sv
module wvc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = wvc_pkg::FIFO_DEPTH,
  localparam int PW = wvc_pkg::bits_for(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_entry,
  input  logic             pop,
  output logic [WIDTH-1:0] head_entry,
  output logic             empty,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    head, tail;

  assign empty      = (count == '0);
  assign head_entry = slots[head];

  // Store at the tail
  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_entry;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == PW'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == PW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (count != CW'(DEPTH)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue pop while empty");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue fill count above depth");

endmodule

### hw/rtl/wvc_back.sv
module wvc_back #(
  parameter int MAX_EXTENT = wvc_pkg::MAX_EXTENT_DEF,
  parameter int DATA_WIDTH = wvc_pkg::DATA_WIDTH_DEF,
  localparam int DEPTH = MAX_EXTENT * MAX_EXTENT * MAX_EXTENT,
  localparam int AW = wvc_pkg::bits_for(DEPTH)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         empty,
  input  logic [wvc_pkg::OP_W-1:0]     entry_op,
  input  logic                         entry_inside,
  input  logic [AW-1:0]                entry_idx,
  input  logic [DATA_WIDTH-1:0]        entry_data,
  output logic                         pop,
  output logic                         done,
  output logic [wvc_pkg::STATUS_W-1:0] status,
  output logic [DATA_WIDTH-1:0]        read_data,
  output logic                         sweeping
);

  logic [DATA_WIDTH-1:0] payload_mem [DEPTH];
  logic                  valid_mem   [DEPTH];

  wvc_pkg::back_state_t  state, state_next;
  logic [AW-1:0]         sweep_addr;
  logic                  sweep_last;

  logic                  vm_we;
  logic [AW-1:0]         vm_addr;
  logic                  vm_din;
  logic                  pm_we;

  logic [DATA_WIDTH-1:0] payload_q;
  logic                  valid_q;
  logic [wvc_pkg::OP_W-1:0] r_op;
  logic                  r_inside;
  wvc_pkg::status_t      st;
  logic                  hit;

  assign sweep_last = (sweep_addr == AW'(DEPTH - 1));

  // Next state: a clear starts a sweep, the last entry ends it
  always_comb begin
    state_next = state;
    case (state)
      wvc_pkg::BK_RUN: begin
        if (pop && (entry_op == wvc_pkg::OP_CLEAR)) begin
          state_next = wvc_pkg::BK_SWEEP;
        end
      end
      wvc_pkg::BK_SWEEP: begin
        if (sweep_last) begin
          state_next = wvc_pkg::BK_RUN;
        end
      end
      default: state_next = wvc_pkg::BK_SWEEP;
    endcase
  end

  // State outputs
  always_comb begin
    case (state)
      wvc_pkg::BK_RUN: begin
        pop      = !empty;
        sweeping = 1'b0;
      end
      wvc_pkg::BK_SWEEP: begin
        pop      = 1'b0;
        sweeping = 1'b1;
      end
      default: begin
        pop      = 1'b0;
        sweeping = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= wvc_pkg::BK_SWEEP;
      sweep_addr <= '0;
    end else begin
      state <= state_next;
      if (sweeping) begin
        sweep_addr <= sweep_last ? '0 : sweep_addr + 1'b1;
      end
    end
  end

  // Valid port: sweep clears, a write in the window sets
  assign pm_we   = pop && (entry_op == wvc_pkg::OP_WRITE) && entry_inside;
  assign vm_we   = sweeping || pm_we;
  assign vm_addr = sweeping ? sweep_addr : entry_idx;
  assign vm_din  = !sweeping;

  always_ff @(posedge clk) begin
    if (vm_we) begin
      valid_mem[vm_addr] <= vm_din;
    end
    if (pop) begin
      valid_q <= valid_mem[entry_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (pm_we) begin
      payload_mem[entry_idx] <= entry_data;
    end
    if (pop) begin
      payload_q <= payload_mem[entry_idx];
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      r_op     <= entry_op;
      r_inside <= entry_inside;
    end
  end

  always_comb begin
    hit = 1'b0;
    case (wvc_pkg::op_t'(r_op))
      wvc_pkg::OP_WRITE: st = r_inside ? wvc_pkg::ST_OK : wvc_pkg::ST_OUTSIDE;
      wvc_pkg::OP_READ: begin
        if (!r_inside) begin
          st = wvc_pkg::ST_OUTSIDE;
        end else if (!valid_q) begin
          st = wvc_pkg::ST_EMPTY;
        end else begin
          st  = wvc_pkg::ST_OK;
          hit = 1'b1;
        end
      end
      default: st = wvc_pkg::ST_OK;
    endcase
  end

  assign status    = st;
  assign read_data = hit ? payload_q : '0;

  a_pop_gives_result: assert property (@(posedge clk) disable iff (rst)
    pop |=> done)
    else $error("popped item gave no result");

  a_clear_sweeps: assert property (@(posedge clk) disable iff (rst)
    (pop && (entry_op == wvc_pkg::OP_CLEAR)) |=> (state == wvc_pkg::BK_SWEEP))
    else $error("clear did not start a sweep");

  a_sweep_blocks_pop: assert property (@(posedge clk) disable iff (rst)
    $past(sweeping) && !sweep_last && sweeping |-> !done)
    else $error("result during sweep");

endmodule
